// File: rtl/core/semg_pkg.sv
// Package for the stereo envelope masking gain block.
// Holds the configuration register indexes, reset values, the control types
// and the sequencer states. It depends on nothing.
package semg_pkg;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 25;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_COEF  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_COEF = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMP_SLOPE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMP_MAX     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENV_GATE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_GATE  = 3'd5;

  // Register values after reset.
  localparam logic [24:0] ATTACK_COEF_RST  = 25'd16777;
  localparam logic [24:0] RELEASE_COEF_RST = 25'd1678;
  localparam logic [15:0] COMP_SLOPE_RST   = 16'd9830;
  localparam logic [14:0] COMP_MAX_RST     = 15'd21299;
  localparam logic [14:0] ENV_GATE_RST     = 15'd3277;
  localparam logic [14:0] SAMPLE_GATE_RST  = 15'd33;

  // A coefficient of one in Q1.24; larger coefficients are clamped to it.
  localparam logic [24:0] COEF_ONE = 25'h1000000;

  // Unity gain in Q2.14.
  localparam int GAIN_ONE = 16384;

  // Configuration register contents shared by both lanes.
  typedef struct packed {
    logic [24:0] attack_coef;
    logic [24:0] release_coef;
    logic [15:0] comp_slope;
    logic [14:0] comp_max;
    logic [14:0] env_gate;
    logic [14:0] sample_gate;
  } cfg_regs_t;

  // Step strobes from the sequencer to the lanes.
  typedef struct packed {
    logic load;
    logic env_mul;
    logic env_add;
    logic slope_mul;
    logic gain_calc;
    logic out_mul;
  } lane_ctrl_t;

  // Sequencer states: idle, then one per step of the lane sequence.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_ADD,
    ST_SLOPE_MUL,
    ST_GAIN,
    ST_OUT_MUL,
    ST_DONE
  } semg_state_t;

endpackage

// File: rtl/core/semg_if.sv
// Channel interfaces of the stereo envelope masking gain block.
// Sample request channel, result channel and configuration write channel.
// Depends on semg_pkg for the configuration port widths.

interface semg_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface semg_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          clipped;

  modport source (output valid, output left_out, output right_out, output clipped,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input clipped,
                  output ready);
endinterface

interface semg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [semg_pkg::CFG_INDEX_W-1:0]   index;
  logic [semg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/semg_lane.sv
// One channel lane: envelope follower and compensation gain for one sample.
// Steps are strobed by the sequencer in the top level.
// Depends on semg_pkg.
module semg_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  semg_pkg::lane_ctrl_t          ctrl,
  input  semg_pkg::cfg_regs_t           cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          clip
);

  localparam int SHIFT = 32 - SAMPLE_BITS;
  localparam int P3_W  = SAMPLE_BITS + 18;

  localparam logic signed [58:0]     ROUND24 = 59'sd8388608;
  localparam logic signed [49:0]     ROUND33 = 50'sd4294967296;
  localparam logic signed [49:0]     UNITY   = 50'(semg_pkg::GAIN_ONE);
  localparam logic signed [P3_W-1:0] ROUND14 = P3_W'(8192);
  localparam logic signed [P3_W-1:0] SAT_HI  =
    {{(P3_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [P3_W-1:0] SAT_LO  = ~SAT_HI;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic [31:0]                   mag;
  logic [31:0]                   env;
  logic signed [58:0]            prod1;
  logic signed [49:0]            prod2;
  logic                          gate;
  logic signed [17:0]            gain;
  logic signed [P3_W-1:0]        prod3;

  logic signed [32:0]  in_q31;
  logic signed [32:0]  in_abs;
  logic signed [32:0]  s_q31;
  logic signed [32:0]  diff;
  logic [24:0]         coef_raw;
  logic [24:0]         coef;
  logic signed [58:0]  env_sum;
  logic signed [32:0]  env_minus_mag;
  logic                gate_next;
  logic signed [49:0]  gain_rnd;
  logic signed [49:0]  gain_full;
  logic signed [49:0]  gain_cap;
  logic signed [P3_W-1:0] y_rnd;
  logic                y_over;
  logic                y_under;

  // Magnitude of the incoming sample in Q1.31.
  always_comb begin
    in_q31 = 33'(sample_in) <<< SHIFT;
    in_abs = in_q31[32] ? -in_q31 : in_q31;
    s_q31  = 33'(sample) <<< SHIFT;
  end

  // Envelope step: pick attack or release, clamp to one.
  always_comb begin
    diff     = $signed({1'b0, mag}) - $signed({1'b0, env});
    coef_raw = (diff > 33'sd0) ? cfg.attack_coef : cfg.release_coef;
    coef     = (coef_raw > semg_pkg::COEF_ONE) ? semg_pkg::COEF_ONE : coef_raw;
    env_sum  = $signed({27'd0, env}) + ((prod1 + ROUND24) >>> 24);
  end

  // Gates and distance of the updated envelope from the magnitude.
  always_comb begin
    env_minus_mag = $signed({1'b0, env}) - $signed({1'b0, mag});
    gate_next     = (s_q31 > $signed({2'b00, cfg.sample_gate, 16'd0})) &&
                    (env > {1'b0, cfg.env_gate, 16'd0});
  end

  // Compensation gain, capped.
  always_comb begin
    gain_rnd  = (prod2 + ROUND33) >>> 33;
    gain_full = gain_rnd + UNITY;
    gain_cap  = $signed({35'd0, cfg.comp_max});
  end

  // Rounding and saturation of the scaled sample; the sample passes unchanged when the gate is closed.
  always_comb begin
    y_rnd   = (prod3 + ROUND14) >>> 14;
    y_over  = y_rnd > SAT_HI;
    y_under = y_rnd < SAT_LO;
    if (!gate) begin
      result = sample;
    end else if (y_over) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y_under) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = y_rnd[SAMPLE_BITS-1:0];
    end
    clip = gate && (y_over || y_under);
  end

  // Envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      env <= '0;
    end else if (ctrl.env_add) begin
      env <= env_sum[31:0];
    end
  end

  // Datapath registers, loaded by the step strobes.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample <= sample_in;
      mag    <= in_abs[31:0];
    end
    if (ctrl.env_mul) begin
      prod1 <= 59'($signed({1'b0, coef})) * 59'(diff);
    end
    if (ctrl.slope_mul) begin
      prod2 <= 50'($signed({1'b0, cfg.comp_slope})) * 50'(env_minus_mag);
      gate  <= gate_next;
    end
    if (ctrl.gain_calc) begin
      gain <= (gain_full > gain_cap) ? gain_cap[17:0] : gain_full[17:0];
    end
    if (ctrl.out_mul) begin
      prod3 <= P3_W'(sample) * P3_W'(gain);
    end
  end

endmodule

// File: rtl/core/semg_merge.sv
// Merging stage: joins both lane results into one result request and holds
// it in the output register until the receiver takes it.
// Depends on semg_out_if.
module semg_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          capture,
  input  logic signed [SAMPLE_BITS-1:0] left_res,
  input  logic signed [SAMPLE_BITS-1:0] right_res,
  input  logic                          left_clip,
  input  logic                          right_clip,
  output logic                          out_free,
  semg_out_if.source                    result_ch
);

  logic                          valid;
  logic                          valid_next;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          clipped;

  // The register can take a new result when empty or drained this cycle.
  assign out_free = !valid || result_ch.ready;

  always_comb begin
    valid_next = valid;
    if (capture) begin
      valid_next = 1'b1;
    end else if (result_ch.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload; clipped is set when either lane saturated.
  always_ff @(posedge clk) begin
    if (capture) begin
      left_out  <= left_res;
      right_out <= right_res;
      clipped   <= left_clip || right_clip;
    end
  end

  assign result_ch.valid     = valid;
  assign result_ch.left_out  = left_out;
  assign result_ch.right_out = right_out;
  assign result_ch.clipped   = clipped;

endmodule

// File: rtl/core/stereo_envelope_masking_gain.sv
// Stereo envelope masking gain: top level with configuration registers,
// step sequencer, two channel lanes and the merging stage.
// Depends on semg_pkg, semg_if, semg_lane and semg_merge.
//
// Usage:
//   sample_ch carries one stereo sample pair per request; result_ch returns
//   one request with both compensated samples and the clipped flag.
//   cfg writes one register per request (index, data); it is always ready
//   and an unknown index is ignored. Write only while the block is idle.
// Timing:
//   A request is taken only while the sequencer is idle. The left and right
//   lanes then run six steps side by side: envelope product, envelope update,
//   slope product, gain, output product, then round and merge. The result is
//   captured into the output register in the last step once it is free, and
//   only then does the sequencer go idle and take the next request.
// Reset:
//   Both envelopes clear to zero, registers return to their defaults and
//   the output register empties.
// Stall:
//   A waiting result sits in the output register while the next request is
//   worked on; that request then waits in its last step until the register
//   is free.
module stereo_envelope_masking_gain #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  semg_in_if.sink    sample_ch,
  semg_out_if.source result_ch,
  semg_cfg_if.sink   cfg
);

  semg_pkg::cfg_regs_t   regs;
  semg_pkg::semg_state_t state;
  semg_pkg::semg_state_t state_next;
  semg_pkg::lane_ctrl_t  ctrl;

  logic in_ready;
  logic capture;
  logic out_free;
  logic in_req;

  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;
  logic                          left_clip;
  logic                          right_clip;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attack_coef  <= semg_pkg::ATTACK_COEF_RST;
      regs.release_coef <= semg_pkg::RELEASE_COEF_RST;
      regs.comp_slope   <= semg_pkg::COMP_SLOPE_RST;
      regs.comp_max     <= semg_pkg::COMP_MAX_RST;
      regs.env_gate     <= semg_pkg::ENV_GATE_RST;
      regs.sample_gate  <= semg_pkg::SAMPLE_GATE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        semg_pkg::CFG_ATTACK_COEF:  regs.attack_coef  <= cfg.data;
        semg_pkg::CFG_RELEASE_COEF: regs.release_coef <= cfg.data;
        semg_pkg::CFG_COMP_SLOPE:   regs.comp_slope   <= cfg.data[15:0];
        semg_pkg::CFG_COMP_MAX:     regs.comp_max     <= cfg.data[14:0];
        semg_pkg::CFG_ENV_GATE:     regs.env_gate     <= cfg.data[14:0];
        semg_pkg::CFG_SAMPLE_GATE:  regs.sample_gate  <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= semg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_req = sample_ch.valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      semg_pkg::ST_IDLE:      if (in_req) state_next = semg_pkg::ST_ENV_MUL;
      semg_pkg::ST_ENV_MUL:   state_next = semg_pkg::ST_ENV_ADD;
      semg_pkg::ST_ENV_ADD:   state_next = semg_pkg::ST_SLOPE_MUL;
      semg_pkg::ST_SLOPE_MUL: state_next = semg_pkg::ST_GAIN;
      semg_pkg::ST_GAIN:      state_next = semg_pkg::ST_OUT_MUL;
      semg_pkg::ST_OUT_MUL:   state_next = semg_pkg::ST_DONE;
      semg_pkg::ST_DONE:      if (out_free) state_next = semg_pkg::ST_IDLE;
      default:                state_next = semg_pkg::ST_IDLE;
    endcase
  end

  // Step strobes and handshake outputs.
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    capture  = 1'b0;
    unique case (state)
      semg_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_req;
      end
      semg_pkg::ST_ENV_MUL:   ctrl.env_mul   = 1'b1;
      semg_pkg::ST_ENV_ADD:   ctrl.env_add   = 1'b1;
      semg_pkg::ST_SLOPE_MUL: ctrl.slope_mul = 1'b1;
      semg_pkg::ST_GAIN:      ctrl.gain_calc = 1'b1;
      semg_pkg::ST_OUT_MUL:   ctrl.out_mul   = 1'b1;
      semg_pkg::ST_DONE:      capture        = out_free;
      default: ;
    endcase
  end

  assign sample_ch.ready = in_ready;

  // Left and right lanes.
  semg_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (regs),
    .sample_in (sample_ch.left_sample),
    .result    (left_res),
    .clip      (left_clip)
  );

  semg_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (regs),
    .sample_in (sample_ch.right_sample),
    .result    (right_res),
    .clip      (right_clip)
  );

  // Merge both lanes into the output register.
  semg_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .capture    (capture),
    .left_res   (left_res),
    .right_res  (right_res),
    .left_clip  (left_clip),
    .right_clip (right_clip),
    .out_free   (out_free),
    .result_ch  (result_ch)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stereo_envelope_masking_gain: a directed table,
// then randomized phases under changing register settings, checked by a local
// envelope and gain predictor. Depends on semg_pkg, the semg_if interfaces and the RTL.
module tb_top;

  localparam int SB            = 16;
  localparam int CFG_IW        = semg_pkg::CFG_INDEX_W;
  localparam int CFG_DW        = semg_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASES        = 10;
  localparam int PHASE_PAIRS   = 142;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 10;
  localparam longint OUT_MAX   = (longint'(1) << (SB - 1)) - 1;
  localparam longint OUT_MIN   = -OUT_MAX - 1;

  // Indexes that map to no register; writes to them must have no effect.
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED_B = 3'd7;
  localparam logic [CFG_DW-1:0] DATA_ALL_ONES  = '1;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;
  typedef enum logic [1:0] {MIX_ANY, MIX_LOUD, MIX_QUIET, MIX_GATE} loudness_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 clipped;
  } stereo_result_t;

  // One line of the directed table: a register write or a sample pair.
  // A pair marked as pass-through must come back unchanged and unclipped.
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IW-1:0]      index;
    logic [CFG_DW-1:0]      data;
    logic signed [SB-1:0]   left;
    logic signed [SB-1:0]   right;
    bit                     passes;
    stereo_result_t         result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  semg_in_if  #(.SAMPLE_BITS(SB)) sample_ch ();
  semg_out_if #(.SAMPLE_BITS(SB)) result_ch ();
  semg_cfg_if                     cfg_ch ();

  stereo_envelope_masking_gain #(.SAMPLE_BITS(SB)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch.sink),
    .result_ch (result_ch.source),
    .cfg       (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Shadow of the block: register contents and both envelopes.
  semg_pkg::cfg_regs_t model_cfg;
  logic [31:0]         env_left;
  logic [31:0]         env_right;
  stereo_result_t      pending_results[$];
  stim_row_t           directed_rows[$];

  int pairs_sent;
  int results_seen;
  int clipped_seen;
  int cfg_writes;
  int mismatches;
  int unexpected_results;
  int reported;
  bit sample_offered;
  bit cfg_open;
  bit gaps_on;
  bit stalls_on;
  bit hold_request;

  // Round to nearest with ties upward: floor((p + half) / 2^n).
  function automatic longint round_shr(longint p, int n);
    return (p + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Envelope update and masking gain for one channel.
  function automatic logic signed [SB-1:0] comp_channel(input logic signed [SB-1:0] s,
                                                        inout logic [31:0] env,
                                                        inout logic clip);
    longint s31, mag, e, diff, coef, gain, y;
    s31  = longint'(s) <<< (32 - SB);
    mag  = (s31 < 0) ? -s31 : s31;
    e    = longint'(env);
    diff = mag - e;
    coef = (diff > 0) ? longint'(model_cfg.attack_coef) : longint'(model_cfg.release_coef);
    if (coef > longint'(semg_pkg::COEF_ONE)) coef = longint'(semg_pkg::COEF_ONE);
    e   = e + round_shr(coef * diff, 24);
    env = e[31:0];
    // Both gates are strict; the sample gate looks at the signed sample.
    if (s31 > (longint'(model_cfg.sample_gate) <<< 16) &&
        e > (longint'(model_cfg.env_gate) <<< 16)) begin
      gain = longint'(semg_pkg::GAIN_ONE) +
             round_shr(longint'(model_cfg.comp_slope) * (e - mag), 33);
      if (gain > longint'(model_cfg.comp_max)) gain = longint'(model_cfg.comp_max);
      y = round_shr(longint'(s) * gain, 14);
      if (y > OUT_MAX) begin
        y    = OUT_MAX;
        clip = 1'b1;
      end else if (y < OUT_MIN) begin
        y    = OUT_MIN;
        clip = 1'b1;
      end
      return y[SB-1:0];
    end
    return s;
  endfunction

  function automatic stereo_result_t predict_pair(logic signed [SB-1:0] l,
                                                  logic signed [SB-1:0] r);
    stereo_result_t res;
    logic           clip;
    clip        = 1'b0;
    res.left    = comp_channel(l, env_left, clip);
    res.right   = comp_channel(r, env_right, clip);
    res.clipped = clip;
    return res;
  endfunction

  // Register write as the block sees it; narrow registers keep their low bits.
  function automatic void apply_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    case (idx)
      semg_pkg::CFG_ATTACK_COEF:  model_cfg.attack_coef  = d[24:0];
      semg_pkg::CFG_RELEASE_COEF: model_cfg.release_coef = d[24:0];
      semg_pkg::CFG_COMP_SLOPE:   model_cfg.comp_slope   = d[15:0];
      semg_pkg::CFG_COMP_MAX:     model_cfg.comp_max     = d[14:0];
      semg_pkg::CFG_ENV_GATE:     model_cfg.env_gate     = d[14:0];
      semg_pkg::CFG_SAMPLE_GATE:  model_cfg.sample_gate  = d[14:0];
      default: ;
    endcase
  endfunction

  // Idle stretch: mostly short, now and then a long one.
  function automatic int idle_span();
    return ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 3))
                                        : int'($urandom_range(10, 40));
  endfunction

  function automatic logic signed [SB-1:0] next_sample(loudness_t mix);
    int v;
    case (mix)
      MIX_LOUD:  v = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(16000, 32768))
                                                 : int'($urandom_range(16000, 32767));
      MIX_QUIET: v = int'($urandom_range(0, 600)) - 300;
      MIX_GATE:  v = int'(model_cfg.sample_gate) + int'($urandom_range(0, 4)) - 2;
      default:   v = int'($urandom);
    endcase
    return v[SB-1:0];
  endfunction

  function automatic void add_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    directed_rows.push_back('{ROW_CONFIG, idx, d, '0, '0, 1'b0, '0});
  endfunction

  function automatic void add_pair(int l, int r, bit passes);
    logic signed [SB-1:0] ls;
    logic signed [SB-1:0] rs;
    ls = SB'(l);
    rs = SB'(r);
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, ls, rs, passes,
                              stereo_result_t'{ls, rs, 1'b0}});
  endfunction

  // Stop offering pairs, wait for every result, then give the block time to go idle.
  task automatic settle();
    if (sample_offered) begin
      sample_ch.valid <= 1'b0;
      sample_offered = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the first write of a group waits until the block is idle.
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    if (!cfg_open) settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    cfg_open = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, d);
    cfg_writes++;
  endtask

  // Offer one stereo request; valid stays high afterwards for back-to-back pairs.
  task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                           input bit passes);
    int             gap;
    stereo_result_t predicted;
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = (gaps_on && $urandom_range(0, 99) < 45) ? idle_span() : 0;
    if (gap > 0) begin
      if (sample_offered) sample_ch.valid <= 1'b0;
      sample_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.left_sample  <= l;
    sample_ch.right_sample <= r;
    sample_offered = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = predict_pair(l, r);
    pending_results.push_back(passes ? stereo_result_t'{l, r, 1'b0} : predicted);
    pairs_sent++;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!stalls_on || $urandom_range(0, 99) < 65) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    stereo_result_t got;
    stereo_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.left_out, result_ch.right_out, result_ch.clipped};
      results_seen++;
      if (got.clipped) clipped_seen++;
      if (pending_results.size() == 0) begin
        unexpected_results++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("Unexpected result: left %0d right %0d clipped %0b",
                   got.left, got.right, got.clipped);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.clipped !== want.clipped) begin
          mismatches++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("Mismatch on result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     results_seen, want.left, want.right, want.clipped,
                     got.left, got.right, got.clipped);
          end
        end
      end
    end
  end

  // Stimulus: directed table first, then randomized phases.
  initial begin
    int                waited;
    int                mix_left;
    loudness_t         mix;
    logic [CFG_DW-1:0] attack_d, release_d, slope_d, max_d, env_gate_d, smp_gate_d;

    sample_ch.valid        <= 1'b0;
    sample_ch.left_sample  <= '0;
    sample_ch.right_sample <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= '0;
    cfg_ch.data            <= '0;
    model_cfg = '{semg_pkg::ATTACK_COEF_RST, semg_pkg::RELEASE_COEF_RST,
                  semg_pkg::COMP_SLOPE_RST, semg_pkg::COMP_MAX_RST,
                  semg_pkg::ENV_GATE_RST, semg_pkg::SAMPLE_GATE_RST};
    env_left  = '0;
    env_right = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    mix_left  = 0;
    mix       = MIX_ANY;

    // Right after reset the envelopes are near zero, so nothing is compensated.
    add_pair(0, 0, 1'b1);
    add_pair(-32768, 32767, 1'b1);
    add_pair(32767, -32768, 1'b1);
    add_pair(-1, 1, 1'b1);
    add_pair(33, 34, 1'b1);
    add_pair(-32768, -32768, 1'b1);
    // Full attack, release coefficient above one, open gates, strongest gain.
    add_cfg(semg_pkg::CFG_ATTACK_COEF, semg_pkg::COEF_ONE);
    add_cfg(semg_pkg::CFG_RELEASE_COEF, DATA_ALL_ONES);
    add_cfg(semg_pkg::CFG_COMP_SLOPE, 25'hFFFF);
    add_cfg(semg_pkg::CFG_COMP_MAX, 25'h7FFF);
    add_cfg(semg_pkg::CFG_ENV_GATE, 25'd0);
    add_cfg(semg_pkg::CFG_SAMPLE_GATE, 25'd0);
    add_pair(32767, 16384, 1'b0);
    add_pair(100, 32767, 1'b0);
    // Envelope holds at full scale, so quiet samples get the capped gain.
    add_cfg(semg_pkg::CFG_RELEASE_COEF, 25'd0);
    add_pair(32767, 32767, 1'b0);
    add_pair(1, 1000, 1'b0);
    add_pair(20000, 30000, 1'b0);
    add_pair(-20000, 0, 1'b1);
    // Cap below unity: a zero cap silences compensated samples.
    add_cfg(semg_pkg::CFG_COMP_MAX, 25'd0);
    add_pair(12345, 32767, 1'b0);
    // Upper data bits of the narrow registers are dropped; gates at their top.
    add_cfg(semg_pkg::CFG_COMP_MAX, 25'h1FFC000);
    add_cfg(semg_pkg::CFG_COMP_SLOPE, 25'h1FF0000);
    add_cfg(semg_pkg::CFG_ENV_GATE, DATA_ALL_ONES);
    add_cfg(semg_pkg::CFG_SAMPLE_GATE, DATA_ALL_ONES);
    add_pair(32767, 32767, 1'b1);
    // Writes to unmapped indexes change nothing.
    add_cfg(CFG_UNMAPPED_A, DATA_ALL_ONES);
    add_cfg(CFG_UNMAPPED_B, 25'd0);
    add_cfg(semg_pkg::CFG_ENV_GATE, 25'd100);
    add_cfg(semg_pkg::CFG_SAMPLE_GATE, 25'd100);
    add_pair(32767, 5000, 1'b0);
    // No attack, instant release.
    add_cfg(semg_pkg::CFG_ATTACK_COEF, 25'd0);
    add_cfg(semg_pkg::CFG_RELEASE_COEF, semg_pkg::COEF_ONE);
    add_pair(32767, -32768, 1'b0);
    add_pair(0, 0, 1'b0);
    add_pair(30000, 30000, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_reg(directed_rows[i].index, directed_rows[i].data);
      else
        send_pair(directed_rows[i].left, directed_rows[i].right, directed_rows[i].passes);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on   = (phase % 3 != 1);
      stalls_on = (phase % 4 != 2);
      case (phase)
        0: begin
          attack_d   = semg_pkg::ATTACK_COEF_RST;
          release_d  = semg_pkg::RELEASE_COEF_RST;
          slope_d    = CFG_DW'(semg_pkg::COMP_SLOPE_RST);
          max_d      = CFG_DW'(semg_pkg::COMP_MAX_RST);
          env_gate_d = CFG_DW'(semg_pkg::ENV_GATE_RST);
          smp_gate_d = CFG_DW'(semg_pkg::SAMPLE_GATE_RST);
        end
        1: begin
          attack_d   = '0;
          release_d  = '0;
          slope_d    = '0;
          max_d      = CFG_DW'(semg_pkg::GAIN_ONE);
          env_gate_d = '0;
          smp_gate_d = '0;
        end
        2: begin
          attack_d   = DATA_ALL_ONES;
          release_d  = DATA_ALL_ONES;
          slope_d    = 25'hFFFF;
          max_d      = 25'h7FFF;
          env_gate_d = 25'h7FFF;
          smp_gate_d = 25'h7FFF;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       attack_d = semg_pkg::COEF_ONE;
            1:       attack_d = CFG_DW'($urandom_range(1 << 16, 1 << 22));
            2:       attack_d = CFG_DW'($urandom);
            default: attack_d = CFG_DW'($urandom_range(1000, 100000));
          endcase
          case ($urandom_range(0, 3))
            0:       release_d = '0;
            1:       release_d = CFG_DW'($urandom_range(0, 1 << 16));
            2:       release_d = CFG_DW'($urandom);
            default: release_d = CFG_DW'($urandom_range(1 << 16, 1 << 23));
          endcase
          slope_d    = ($urandom_range(0, 1) == 0) ? CFG_DW'($urandom_range(0, 65535))
                                                   : CFG_DW'($urandom);
          max_d      = ($urandom_range(0, 4) != 0)
                       ? CFG_DW'($urandom_range(semg_pkg::GAIN_ONE, 32767))
                       : CFG_DW'($urandom);
          env_gate_d = CFG_DW'($urandom_range(0, 12000));
          smp_gate_d = CFG_DW'($urandom_range(0, 4000));
        end
      endcase
      write_reg(semg_pkg::CFG_ATTACK_COEF, attack_d);
      write_reg(semg_pkg::CFG_RELEASE_COEF, release_d);
      write_reg(semg_pkg::CFG_COMP_SLOPE, slope_d);
      write_reg(semg_pkg::CFG_COMP_MAX, max_d);
      write_reg(semg_pkg::CFG_ENV_GATE, env_gate_d);
      write_reg(semg_pkg::CFG_SAMPLE_GATE, smp_gate_d);
      if (phase % 3 == 0) write_reg(CFG_UNMAPPED_A, CFG_DW'($urandom));

      // Back-to-back pairs against a long hold-off fill the block and stall its input.
      if (phase == 4) begin
        gaps_on      = 1'b0;
        hold_request = 1'b1;
      end

      // Bursts of loud, quiet and near-gate material drive attack, release and masking.
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        if (phase == 6 && n == PHASE_PAIRS / 2) settle();
        if (mix_left == 0) begin
          mix      = loudness_t'($urandom_range(0, 3));
          mix_left = $urandom_range(4, 30);
        end
        mix_left--;
        send_pair(next_sample(mix), next_sample(mix), 1'b0);
      end
    end

    // Drain, with a bound in case results stop coming.
    if (sample_offered) sample_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d stereo pairs over %0d register writes; %0d clipped.",
             results_seen, pairs_sent, cfg_writes, clipped_seen);
    $display("Errors: %0d mismatched, %0d unexpected, %0d missing results.",
             mismatches, unexpected_results, pending_results.size());
    if (mismatches == 0 && unexpected_results == 0 && pending_results.size() == 0)
      $display("PASS stereo_envelope_masking_gain");
    else
      $display("FAIL stereo_envelope_masking_gain");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL stereo_envelope_masking_gain");
    $finish;
  end

endmodule
